### design/rdb_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and sizes for the request dedup / backoff table.
// Used by rdb_table and request_dedup_backoff_table_core. No dependencies.
`default_nettype none

package rdb_pkg;

  localparam int ENTRIES   = 32;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int KEY_W     = 256;
  localparam int TIME_W    = 64;
  localparam int TALLY_W   = 5;
  localparam int SLOT_W    = 5;
  localparam int LEN_W     = 16;
  localparam int TAG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam logic [IDX_W-1:0]   LAST_IDX    = IDX_W'(ENTRIES - 1);
  localparam logic [TALLY_W-1:0] TALLY_MAX   = 5'd16;
  localparam logic [TALLY_W-1:0] BLOCK_AFTER = 5'd3;
  localparam logic [LEN_W-1:0]   MIN_LEN     = 16'd5;

  // input kinds
  localparam logic [1:0] KIND_REQ    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  // result status codes
  localparam logic [2:0] ST_DELIVERED = 3'd0;
  localparam logic [2:0] ST_BAD_LEN   = 3'd1;
  localparam logic [2:0] ST_NO_HANDLR = 3'd2;
  localparam logic [2:0] ST_REPEAT    = 3'd3;
  localparam logic [2:0] ST_TAG_BAD   = 3'd4;
  localparam logic [2:0] ST_FILTERED  = 3'd5;
  localparam logic [2:0] ST_REMOVED   = 3'd6;
  localparam logic [2:0] ST_NOT_FOUND = 3'd7;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NOSPAM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HANDLER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic [KEY_W-1:0]   digest;
    logic [TIME_W-1:0]  stamp;
    logic [TALLY_W-1:0] tally;
  } rec_t;

  typedef struct packed {
    logic en;
    idx_t addr;
  } rd_req_t;

  typedef struct packed {
    logic en;
    idx_t addr;
    key_t key;
  } key_wr_t;

  typedef struct packed {
    logic en;
    idx_t addr;
    rec_t rec;
  } rec_wr_t;

  function automatic logic [SLOT_W-1:0] to_slot(idx_t i);
    logic [IDX_W+SLOT_W-1:0] wide;
    wide = {{SLOT_W{1'b0}}, i};
    return wide[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

### design/rdb_table.sv
`timescale 1ns / 1ps
// Entry storage: key memory and record memory (digest, stamp, tally),
// registered reads, per-row valid bits. Depends on rdb_pkg.
`default_nettype none

module rdb_table
  import rdb_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  input  wire rd_req_t key_rd,
  input  wire key_wr_t key_wr,
  output key_t         key_q,
  input  wire rd_req_t rec_rd,
  input  wire rec_wr_t rec_wr,
  output rec_t         rec_q
);

  key_t key_mem [ENTRIES];
  rec_t rec_mem [ENTRIES];

  logic [ENTRIES-1:0] key_vld_r;
  logic [ENTRIES-1:0] rec_vld_r;
  key_t               key_q_r;
  rec_t               rec_q_r;
  logic               key_hit_r;
  logic               rec_hit_r;

  always_ff @(posedge clk) begin
    if (key_wr.en) begin
      key_mem[key_wr.addr] <= key_wr.key;
    end
    if (key_rd.en) begin
      key_q_r <= key_mem[key_rd.addr];
    end
    if (rec_wr.en) begin
      rec_mem[rec_wr.addr] <= rec_wr.rec;
    end
    if (rec_rd.en) begin
      rec_q_r <= rec_mem[rec_rd.addr];
    end
  end

  // rows never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_vld_r <= '0;
      rec_vld_r <= '0;
      key_hit_r <= 1'b0;
      rec_hit_r <= 1'b0;
    end else begin
      if (key_wr.en) begin
        key_vld_r[key_wr.addr] <= 1'b1;
      end
      if (rec_wr.en) begin
        rec_vld_r[rec_wr.addr] <= 1'b1;
      end
      if (key_rd.en) begin
        key_hit_r <= key_vld_r[key_rd.addr];
      end
      if (rec_rd.en) begin
        rec_hit_r <= rec_vld_r[rec_rd.addr];
      end
    end
  end

  assign key_q = key_hit_r ? key_q_r : '0;
  assign rec_q = rec_hit_r ? rec_q_r : '0;

endmodule

`default_nettype wire

### design/request_dedup_backoff_table_core.sv
`timescale 1ns / 1ps
// Top level of the request dedup / backoff admission filter.
// Depends on rdb_pkg and rdb_table.
`default_nettype none

//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  in_     | in  | in_tvalid/tready   | tuser: kind; tdata: key, digest, tag, len, flt
//  out_    | out | out_tvalid/tready  | tdata: status, slot_index
//  cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data (nospam, handler, max_len)
//
//  One beat at a time. A request walks the key memory one entry per cycle
//  (read port of the key RAM) until a match, then reads and checks the
//  matched record and rewrites it unless it is a repeat or blocked. A remove
//  clears the matched key. A tick only advances the clock and gives no result.
//  Reset (rst_n, synchronous) clears the valid bits at once; no clearing pass.
//  A finished result waits in the output register; in_tready stays low until
//  the previous result has moved into it.

module request_dedup_backoff_table_core
  import rdb_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  // input stream
  input  wire                  in_tvalid,
  output logic                 in_tready,
  // [63:0] key_word0, [127:64] key_word1, [191:128] key_word2,
  // [255:192] key_word3, [319:256] digest_word0, [383:320] digest_word1,
  // [447:384] digest_word2, [511:448] digest_word3, [543:512] packet_nospam,
  // [559:544] payload_length, [560] filter_rejects, [567:561] zero
  input  wire  [567:0]         in_tdata,
  // [1:0] kind
  input  wire  [1:0]           in_tuser,
  // result stream
  output logic                 out_tvalid,
  input  wire                  out_tready,
  // [2:0] status, [7:3] slot_index
  output logic [7:0]           out_tdata,
  // config writes
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  [CFG_IDX_W-1:0] cfg_index,
  input  wire  [CFG_DAT_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_REC_RD = 3'd2;
  localparam logic [2:0] S_EVAL   = 3'd3;
  localparam logic [2:0] S_RES    = 3'd4;

  // config
  logic [TAG_W-1:0]  own_nospam_r;
  logic              handler_r;
  logic [LEN_W-1:0]  max_len_r;

  // sequencer
  logic [2:0]        state_r, state_nxt;
  idx_t              scan_r, scan_nxt;
  logic              pend_r, pend_nxt;
  idx_t              pend_idx_r, pend_idx_nxt;
  idx_t              match_idx_r, match_idx_nxt;

  // captured beat
  logic [1:0]        kind_r;
  key_t              key_r;
  key_t              dig_r;
  logic [TAG_W-1:0]  tag_r;
  logic              rej_r;

  // result staging and output register
  logic [2:0]        res_status_r, res_status_nxt;
  idx_t              res_slot_r, res_slot_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_status_r;
  logic [SLOT_W-1:0] out_slot_r;

  // ring pointer and clock
  idx_t              write_slot_r, write_slot_nxt;
  logic [TIME_W-1:0] cur_time_r, cur_time_nxt;

  // table ports
  rd_req_t           key_rd, rec_rd;
  key_wr_t           key_wr;
  rec_wr_t           rec_wr;
  key_t              key_q;
  rec_t              rec_q;

  // beat fields
  logic [1:0]        in_kind;
  key_t              in_key, in_dig;
  logic [TAG_W-1:0]  in_tag;
  logic [LEN_W-1:0]  in_len;
  logic              in_rej;
  logic              in_fire;
  logic              out_load;

  // eval path
  logic              is_repeat, is_blocked;
  logic [TALLY_W-1:0] shift_amt, tally_inc;
  logic [TIME_W-1:0] until_time;

  assign in_kind = in_tuser;
  assign in_key  = in_tdata[255:0];
  assign in_dig  = in_tdata[511:256];
  assign in_tag  = in_tdata[543:512];
  assign in_len  = in_tdata[559:544];
  assign in_rej  = in_tdata[560];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  rdb_table u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .key_rd (key_rd),
    .key_wr (key_wr),
    .key_q  (key_q),
    .rec_rd (rec_rd),
    .rec_wr (rec_wr),
    .rec_q  (rec_q)
  );

  // backoff: from tally 3 on, blocked until last accept + 2^min(tally,16), 64-bit wrap
  assign shift_amt  = (rec_q.tally > TALLY_MAX) ? TALLY_MAX : rec_q.tally;
  assign until_time = rec_q.stamp + (TIME_W'(1) << shift_amt);
  assign is_repeat  = (rec_q.digest == dig_r);
  assign is_blocked = (rec_q.tally >= BLOCK_AFTER) && !(until_time <= cur_time_r);
  assign tally_inc  = (rec_q.tally >= TALLY_MAX) ? TALLY_MAX : rec_q.tally + 5'd1;

  always_comb begin
    state_nxt      = state_r;
    scan_nxt       = scan_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    match_idx_nxt  = match_idx_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    write_slot_nxt = write_slot_r;
    cur_time_nxt   = cur_time_r;
    out_load       = 1'b0;
    key_rd         = '0;
    rec_rd         = '0;
    key_wr         = '0;
    rec_wr         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          scan_nxt     = '0;
          pend_nxt     = 1'b0;
          res_slot_nxt = '0;
          case (in_kind)
            KIND_TICK: begin
              cur_time_nxt = cur_time_r + TIME_W'(1);
            end
            KIND_REMOVE: begin
              state_nxt = S_SCAN;
            end
            KIND_REQ: begin
              if (in_len <= MIN_LEN || in_len > max_len_r) begin
                res_status_nxt = ST_BAD_LEN;
                state_nxt      = S_RES;
              end else if (!handler_r) begin
                res_status_nxt = ST_NO_HANDLR;
                state_nxt      = S_RES;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        // read one ahead, compare the row that came back
        key_rd.en    = 1'b1;
        key_rd.addr  = scan_r;
        pend_nxt     = 1'b1;
        pend_idx_nxt = scan_r;
        if (scan_r != LAST_IDX) begin
          scan_nxt = scan_r + idx_t'(1);
        end
        if (pend_r) begin
          if (key_q == key_r) begin
            if (kind_r == KIND_REMOVE) begin
              key_wr.en      = 1'b1;
              key_wr.addr    = pend_idx_r;
              key_wr.key     = '0;
              res_status_nxt = ST_REMOVED;
              res_slot_nxt   = pend_idx_r;
              state_nxt      = S_RES;
            end else begin
              match_idx_nxt = pend_idx_r;
              state_nxt     = S_REC_RD;
            end
          end else if (pend_idx_r == LAST_IDX) begin
            state_nxt = S_RES;
            if (kind_r == KIND_REMOVE) begin
              res_status_nxt = ST_NOT_FOUND;
            end else if (tag_r != own_nospam_r) begin
              res_status_nxt = ST_TAG_BAD;
            end else if (rej_r) begin
              res_status_nxt = ST_FILTERED;
            end else begin
              // new sender takes the next ring slot
              key_wr.en      = 1'b1;
              key_wr.addr    = write_slot_r;
              key_wr.key     = key_r;
              rec_wr.en      = 1'b1;
              rec_wr.addr    = write_slot_r;
              rec_wr.rec     = '{digest: dig_r, stamp: cur_time_r, tally: TALLY_W'(1)};
              res_status_nxt = ST_DELIVERED;
              res_slot_nxt   = write_slot_r;
              write_slot_nxt = (write_slot_r == LAST_IDX) ? '0
                                                          : write_slot_r + idx_t'(1);
            end
          end
        end
      end

      S_REC_RD: begin
        rec_rd.en   = 1'b1;
        rec_rd.addr = match_idx_r;
        state_nxt   = S_EVAL;
      end

      S_EVAL: begin
        res_slot_nxt = match_idx_r;
        state_nxt    = S_RES;
        if (is_repeat || is_blocked) begin
          res_status_nxt = ST_REPEAT;
        end else begin
          // entry update sticks even if tag or filter fails below
          rec_wr.en   = 1'b1;
          rec_wr.addr = match_idx_r;
          rec_wr.rec  = '{digest: dig_r, stamp: cur_time_r, tally: tally_inc};
          if (tag_r != own_nospam_r) begin
            res_status_nxt = ST_TAG_BAD;
          end else if (rej_r) begin
            res_status_nxt = ST_FILTERED;
          end else begin
            res_status_nxt = ST_DELIVERED;
          end
        end
      end

      S_RES: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      scan_r       <= '0;
      pend_r       <= 1'b0;
      pend_idx_r   <= '0;
      match_idx_r  <= '0;
      res_status_r <= ST_DELIVERED;
      res_slot_r   <= '0;
      out_valid_r  <= 1'b0;
      write_slot_r <= '0;
      cur_time_r   <= '0;
      own_nospam_r <= '0;
      handler_r    <= 1'b0;
      max_len_r    <= 16'd1024;
    end else begin
      state_r      <= state_nxt;
      scan_r       <= scan_nxt;
      pend_r       <= pend_nxt;
      pend_idx_r   <= pend_idx_nxt;
      match_idx_r  <= match_idx_nxt;
      res_status_r <= res_status_nxt;
      res_slot_r   <= res_slot_nxt;
      out_valid_r  <= out_valid_nxt;
      write_slot_r <= write_slot_nxt;
      cur_time_r   <= cur_time_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_NOSPAM:  own_nospam_r <= cfg_data;
          CFG_HANDLER: handler_r    <= cfg_data[0];
          CFG_MAX_LEN: max_len_r    <= cfg_data[LEN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= in_kind;
      key_r  <= in_key;
      dig_r  <= in_dig;
      tag_r  <= in_tag;
      rej_r  <= in_rej;
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= to_slot(res_slot_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_slot_r, out_status_r};

endmodule

`default_nettype wire
